FILE: sv/signed_decimal_field_formatter_macros.svh
// assertion macros for the signed decimal field formatter
// no dependencies; included by the rtl file that carries assertions
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define SDFF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdff assertion failed");
// antecedent implies consequent in the next cycle
`define SDFF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdff assertion failed");
`else
`define SDFF_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define SDFF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/sdff_pkg.sv
// types and constants of the signed decimal field formatter
// no dependencies
`default_nettype none

package sdff_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IN_W       = 48;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_ALIGN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: sv/signed_decimal_field_formatter.sv
// sequence: capture, 32 double-dabble steps (one bit each), sizing, digit alignment,
// then one character per cycle to the output register while the output is not stalled
// one item at a time: the next is taken only when the bit-serial binary to bcd loop and
// the one-character-per-beat emitter are done with the last one, and it is taken
// while the last character still waits in the output register
// reset: synchronous active-low aresetn clears the state machine and output valid
`default_nettype none
`include "signed_decimal_field_formatter_macros.svh"

module signed_decimal_field_formatter #(
    parameter int MAX_LEN = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata, low bit up: value[31:0], plus_flag, blank_flag, zero_flag, left_flag,
    // has_precision, precision[4:0], field_width[4:0], one zero fill bit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // m_tdata: char_out[7:0]; m_tuser: char_valid; m_tlast: last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    // counter width: holds MAX_LEN and at least the 5-bit field inputs
    localparam int LEN_BITS = $clog2(MAX_LEN + 1);
    localparam int CNT_W    = (LEN_BITS > 6) ? LEN_BITS : 6;
    localparam int POS_W    = 4;

    localparam logic [CNT_W-1:0] W_MAX = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] P_MAX = CNT_W'(MAX_LEN - 1);

    // ---------------- registers ----------------
    sdff_pkg::state_t state_reg, state_next;

    logic [sdff_pkg::VALUE_W-1:0] mag_reg, mag_next;        // magnitude shift-out register
    logic [sdff_pkg::BCD_W-1:0]   bcd_reg, bcd_next;        // bcd digits, digit 9 on top
    logic [4:0]                   shift_cnt_reg, shift_cnt_next;
    logic                         neg_reg, neg_next;
    logic                         zero_reg, zero_next;
    logic                         left_reg, left_next;
    logic                         has_p_reg, has_p_next;
    logic [4:0]                   prec_reg, prec_next;
    logic [4:0]                   fwidth_reg, fwidth_next;
    logic                         slot_reg, slot_next;      // sign character still to send
    logic [7:0]                   sign_reg, sign_next;
    logic [CNT_W-1:0]             dig_left_reg, dig_left_next; // digit positions still to send
    logic [POS_W-1:0]             pos_reg, pos_next;        // digit index + 1 seen on top nibble

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tuser_reg, m_tuser_next;
    logic       m_tlast_reg, m_tlast_next;

    // ---------------- combinational helpers ----------------
    logic                         s_beat;
    logic                         out_ld;
    logic [sdff_pkg::VALUE_W-1:0] in_value;
    logic [sdff_pkg::BCD_W-1:0]   bcd_adj;
    logic [3:0]                   ndig;
    logic [CNT_W-1:0]             w_sat, p_sat, plain, ndig_ext, len, digits_out;
    logic                         zero_pad, mag_zero, emit_done;
    logic [3:0]                   top_nib;

    assign in_value = s_tdata[31:0];
    assign s_beat   = s_tvalid && s_tready;
    // output register can take a character this cycle
    assign out_ld   = (state_reg == sdff_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign top_nib  = bcd_reg[sdff_pkg::BCD_W-1 -: 4];

    // double dabble correction: each nibble of 5 or more gets 3 added before the shift
    always_comb begin
        for (int k = 0; k < sdff_pkg::BCD_DIGITS; k++) begin
            bcd_adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ? bcd_reg[4*k +: 4] + 4'd3
                                                              : bcd_reg[4*k +: 4];
        end
    end

    // digit count of the magnitude, zero counts as one digit
    always_comb begin
        ndig = 4'd1;
        for (int k = 0; k < sdff_pkg::BCD_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] != 4'd0) begin
                ndig = 4'(k + 1);
            end
        end
    end

    // field sizing, evaluated in the sizing state
    always_comb begin
        mag_zero = (bcd_reg == '0);
        ndig_ext = CNT_W'(ndig);
        w_sat    = (CNT_W'(fwidth_reg) > W_MAX) ? W_MAX : CNT_W'(fwidth_reg);
        p_sat    = (CNT_W'(prec_reg) > P_MAX) ? P_MAX : CNT_W'(prec_reg);
        plain    = ndig_ext + CNT_W'(neg_reg);
        zero_pad = zero_reg && !has_p_reg && !left_reg && (w_sat > plain);
        if (zero_pad) begin
            len = w_sat;
        end else if (has_p_reg && (p_sat > ndig_ext)) begin
            len = p_sat + CNT_W'(slot_reg);
        end else begin
            len = ndig_ext + CNT_W'(slot_reg);
        end
        // zero with an explicit zero precision prints no digit at all
        if (has_p_reg && (prec_reg == 5'd0) && mag_zero) begin
            digits_out = '0;
        end else begin
            digits_out = len - CNT_W'(slot_reg);
        end
    end

    // the current beat is the final one of this conversion
    always_comb begin
        if (slot_reg) begin
            emit_done = (dig_left_reg == '0);
        end else begin
            emit_done = (dig_left_reg <= CNT_W'(1));
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdff_pkg::ST_IDLE: begin
                if (s_beat) begin
                    state_next = sdff_pkg::ST_CONV;
                end
            end
            sdff_pkg::ST_CONV: begin
                if (shift_cnt_reg == 5'd0) begin
                    state_next = sdff_pkg::ST_SIZE;
                end
            end
            sdff_pkg::ST_SIZE: begin
                state_next = sdff_pkg::ST_ALIGN;
            end
            sdff_pkg::ST_ALIGN: begin
                if (!(CNT_W'(pos_reg) > dig_left_reg)) begin
                    state_next = sdff_pkg::ST_EMIT;
                end
            end
            sdff_pkg::ST_EMIT: begin
                if (out_ld && emit_done) begin
                    state_next = sdff_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sdff_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        shift_cnt_next = shift_cnt_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        left_next      = left_reg;
        has_p_next     = has_p_reg;
        prec_next      = prec_reg;
        fwidth_next    = fwidth_reg;
        slot_next      = slot_reg;
        sign_next      = sign_reg;
        dig_left_next  = dig_left_reg;
        pos_next       = pos_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        s_tready       = 1'b0;

        case (state_reg)
            sdff_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_beat) begin
                    neg_next       = in_value[sdff_pkg::VALUE_W-1];
                    mag_next       = in_value[sdff_pkg::VALUE_W-1] ? (~in_value + 32'd1)
                                                                   : in_value;
                    bcd_next       = '0;
                    shift_cnt_next = 5'd31;
                    zero_next      = s_tdata[34];
                    left_next      = s_tdata[35];
                    has_p_next     = s_tdata[36];
                    prec_next      = s_tdata[41:37];
                    fwidth_next    = s_tdata[46:42];
                    // sign priority: minus, then blank, then plus
                    slot_next      = s_tdata[31] || s_tdata[33] || s_tdata[32];
                    if (s_tdata[31]) begin
                        sign_next = sdff_pkg::ASCII_MINUS;
                    end else if (s_tdata[33]) begin
                        sign_next = sdff_pkg::ASCII_SPACE;
                    end else begin
                        sign_next = sdff_pkg::ASCII_PLUS;
                    end
                end
            end
            sdff_pkg::ST_CONV: begin
                // one binary bit into the bcd register per cycle
                bcd_next       = {bcd_adj[sdff_pkg::BCD_W-2:0], mag_reg[sdff_pkg::VALUE_W-1]};
                mag_next       = {mag_reg[sdff_pkg::VALUE_W-2:0], 1'b0};
                shift_cnt_next = shift_cnt_reg - 5'd1;
            end
            sdff_pkg::ST_SIZE: begin
                dig_left_next = digits_out;
                pos_next      = POS_W'(sdff_pkg::BCD_DIGITS);
            end
            sdff_pkg::ST_ALIGN: begin
                // bring digit (dig_left - 1) to the top nibble
                if (CNT_W'(pos_reg) > dig_left_reg) begin
                    bcd_next = {bcd_reg[sdff_pkg::BCD_W-5:0], 4'd0};
                    pos_next = pos_reg - POS_W'(1);
                end
            end
            sdff_pkg::ST_EMIT: begin
                if (out_ld) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = emit_done;
                    if (slot_reg) begin
                        m_tdata_next = sign_reg;
                        m_tuser_next = 1'b1;
                        slot_next    = 1'b0;
                    end else if (dig_left_reg == '0) begin
                        // empty string marker
                        m_tdata_next = sdff_pkg::ASCII_NUL;
                        m_tuser_next = 1'b0;
                    end else begin
                        m_tuser_next  = 1'b1;
                        dig_left_next = dig_left_reg - CNT_W'(1);
                        if (dig_left_reg <= CNT_W'(sdff_pkg::BCD_DIGITS)) begin
                            m_tdata_next = sdff_pkg::ASCII_ZERO | {4'd0, top_nib};
                            bcd_next     = {bcd_reg[sdff_pkg::BCD_W-5:0], 4'd0};
                        end else begin
                            m_tdata_next = sdff_pkg::ASCII_ZERO;
                        end
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sdff_pkg::ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            shift_cnt_reg <= 5'd0;
            slot_reg      <= 1'b0;
            dig_left_reg  <= '0;
            pos_reg       <= '0;
            bcd_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            shift_cnt_reg <= shift_cnt_next;
            slot_reg      <= slot_next;
            dig_left_reg  <= dig_left_next;
            pos_reg       <= pos_next;
            bcd_reg       <= bcd_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        zero_reg    <= zero_next;
        left_reg    <= left_next;
        has_p_reg   <= has_p_next;
        prec_reg    <= prec_next;
        fwidth_reg  <= fwidth_next;
        sign_reg    <= sign_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    `SDFF_ASSERT_NEXT(a_accept_starts_conv, aclk, aresetn, s_beat,
        state_reg == sdff_pkg::ST_CONV)
    `SDFF_ASSERT_NEXT(a_conv_ends_in_size, aclk, aresetn,
        (state_reg == sdff_pkg::ST_CONV) && (shift_cnt_reg == 5'd0),
        state_reg == sdff_pkg::ST_SIZE)
    `SDFF_ASSERT_IMPLY(a_marker_is_last, aclk, aresetn, m_tvalid_reg && !m_tuser_reg,
        m_tlast_reg)
    `SDFF_ASSERT_IMPLY(a_digits_bounded, aclk, aresetn,
        (state_reg == sdff_pkg::ST_EMIT) || (state_reg == sdff_pkg::ST_ALIGN),
        dig_left_reg <= W_MAX)

endmodule

`default_nettype wire
